// ----- rtl/tcsm_pkg.sv -----
`default_nettype none
package tcsm_pkg;

	localparam int SEND_QUEUE_DEPTH = 8;
	localparam int QCW = $clog2(SEND_QUEUE_DEPTH + 1);
	localparam int QPW = (SEND_QUEUE_DEPTH > 1) ? $clog2(SEND_QUEUE_DEPTH) : 1;
	localparam int MAX_OUT = 3;

	localparam logic [5:0] F_ACK = 6'h10;
	localparam logic [5:0] F_RST = 6'h04;
	localparam logic [5:0] F_SYN = 6'h02;
	localparam logic [5:0] F_FIN = 6'h01;

	localparam logic [1:0] TMR_NONE  = 2'd0;
	localparam logic [1:0] TMR_START = 2'd1;
	localparam logic [1:0] TMR_STOP  = 2'd2;

	localparam logic [6:0] SECS_FIN   = 7'd1;
	localparam logic [6:0] SECS_DATA  = 7'd3;
	localparam logic [6:0] SECS_RETX  = 7'd5;
	localparam logic [6:0] SECS_TWAIT = 7'd120;

	localparam logic [15:0] RWIN_RESET = 16'd1500;

	localparam logic [1:0] REG_PASSIVE_OPEN = 2'd0;
	localparam logic [1:0] REG_RECV_WINDOW  = 2'd1;
	localparam logic [1:0] REG_LOCAL_PORT   = 2'd2;
	localparam logic [1:0] REG_PEER_PORT    = 2'd3;

	typedef enum logic [2:0] {
		OP_OPEN    = 3'd0,
		OP_SEG     = 3'd1,
		OP_TIMEOUT = 3'd2,
		OP_CLOSE   = 3'd3,
		OP_SEND    = 3'd4,
		OP_NONE    = 3'd5
	} op_t;

	typedef enum logic [10:0] {
		CS_CLOSED     = 11'b000_0000_0001,
		CS_LISTEN     = 11'b000_0000_0010,
		CS_SYN_SENT   = 11'b000_0000_0100,
		CS_SYN_RCVD   = 11'b000_0000_1000,
		CS_ESTAB      = 11'b000_0001_0000,
		CS_FW1        = 11'b000_0010_0000,
		CS_FW2        = 11'b000_0100_0000,
		CS_TIME_WAIT  = 11'b000_1000_0000,
		CS_CLOSE_WAIT = 11'b001_0000_0000,
		CS_LAST_ACK   = 11'b010_0000_0000,
		CS_CLOSING    = 11'b100_0000_0000
	} conn_t;

	typedef struct packed {
		logic        passive_open;
		logic [15:0] recv_window;
		logic [15:0] peer_port;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [5:0]  seg_flags;
		logic [15:0] data_len;
		logic [15:0] seg_src_port;
		logic [31:0] initial_seq;
	} evt_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] ack;
		logic [5:0]  flags;
		logic [15:0] len;
	} seg_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] out_seq;
		logic [31:0] out_ack;
		logic [5:0]  out_flags;
		logic [15:0] out_len;
		logic [15:0] out_port;
		logic [3:0]  conn_state;
		logic [1:0]  timer_cmd;
		logic [6:0]  timer_secs;
		logic [15:0] deliver_len;
		logic        last;
	} res_t;

	function automatic logic in_win(input logic [31:0] lo, input logic lo_open,
			input logic [31:0] x, input logic hi_open, input logic [31:0] hi);
		logic [31:0] d;
		logic [31:0] s;
		d = x - lo;
		s = hi - lo;
		return !(d > s) && !(lo_open && d == 32'd0) && !(hi_open && d == s);
	endfunction

	function automatic logic [3:0] conn_code(input conn_t c);
		logic [3:0] r;
		case (c)
			CS_CLOSED:     r = 4'd0;
			CS_LISTEN:     r = 4'd1;
			CS_SYN_SENT:   r = 4'd2;
			CS_SYN_RCVD:   r = 4'd3;
			CS_ESTAB:      r = 4'd4;
			CS_FW1:        r = 4'd5;
			CS_FW2:        r = 4'd6;
			CS_TIME_WAIT:  r = 4'd7;
			CS_CLOSE_WAIT: r = 4'd8;
			CS_LAST_ACK:   r = 4'd9;
			CS_CLOSING:    r = 4'd10;
			default:       r = 4'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tcsm_if.sv -----
`default_nettype none
interface tcsm_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] seg_seq;
	logic [31:0] seg_ack;
	logic [5:0]  seg_flags;
	logic [15:0] data_len;
	logic [15:0] seg_src_port;
	logic [31:0] initial_seq;
	modport source (output valid, op, seg_seq, seg_ack, seg_flags, data_len,
		seg_src_port, initial_seq, input ready);
	modport sink (input valid, op, seg_seq, seg_ack, seg_flags, data_len,
		seg_src_port, initial_seq, output ready);
endinterface

interface tcsm_out_if;
	logic        valid;
	logic        ready;
	logic        emit;
	logic [31:0] out_seq;
	logic [31:0] out_ack;
	logic [5:0]  out_flags;
	logic [15:0] out_len;
	logic [15:0] out_port;
	logic [3:0]  conn_state;
	logic [1:0]  timer_cmd;
	logic [6:0]  timer_secs;
	logic [15:0] deliver_len;
	logic        last;
	modport source (output valid, emit, out_seq, out_ack, out_flags, out_len, out_port,
		conn_state, timer_cmd, timer_secs, deliver_len, last, input ready);
	modport sink (input valid, emit, out_seq, out_ack, out_flags, out_len, out_port,
		conn_state, timer_cmd, timer_secs, deliver_len, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/tcp_connection_state_machine.sv -----
`default_nettype none
// Channel   Direction  Carries
// in_ch     sink       one event: op, segment numbers, flags, length, ports, initial seq
// out_ch    source     one result: segment to send, state, timer command, delivered bytes
// cfg_*     write      passive_open, receive_window, local_port, peer_port
//
// An event enters the front queue on its transfer and moves into the execute stage
// when that stage takes it; its first result is offered in the cycle after that.
// The execute stage offers one result per cycle while the output is ready and takes
// the next event on the edge that moves the previous event's last result. Reset is
// asynchronous and puts the connection in CLOSED with both queues empty. A stalled
// output holds its result; the front queue fills and then drops ready.
module tcp_connection_state_machine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tcsm_in_if.sink          in_ch,
	tcsm_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	// Configuration registers. The local port has no use in any result, so
	// writes to it are taken and discarded.
	tcsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.passive_open <= 1'b0;
			cfg_q.recv_window  <= tcsm_pkg::RWIN_RESET;
			cfg_q.peer_port    <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				tcsm_pkg::REG_PASSIVE_OPEN: cfg_q.passive_open <= cfg_wdata[0];
				tcsm_pkg::REG_RECV_WINDOW:  cfg_q.recv_window  <= cfg_wdata;
				tcsm_pkg::REG_LOCAL_PORT:   ;
				tcsm_pkg::REG_PEER_PORT:    cfg_q.peer_port    <= cfg_wdata;
				default:                    ;
			endcase
		end
	end

	// The front classifies events and queues them; the back executes them
	// in order against the connection state and drains their results.
	tcsm_pkg::evt_t evt;
	logic           evt_valid;
	logic           evt_ready;

	tcsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.evt       (evt),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready)
	);

	tcsm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt       (evt),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.out_ch    (out_ch)
	);
endmodule
`default_nettype wire

// ----- rtl/tcsm_front.sv -----
`default_nettype none
// Accepts events, classifies the op code and holds them in a two-entry queue.
module tcsm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tcsm_in_if.sink            in_ch,
	output tcsm_pkg::evt_t     evt,
	output logic               evt_valid,
	input  wire logic          evt_ready
);
	tcsm_pkg::evt_t q_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	tcsm_pkg::op_t  op_c;

	always_comb begin
		case (in_ch.op)
			3'd0:    op_c = tcsm_pkg::OP_OPEN;
			3'd1:    op_c = tcsm_pkg::OP_SEG;
			3'd2:    op_c = tcsm_pkg::OP_TIMEOUT;
			3'd3:    op_c = tcsm_pkg::OP_CLOSE;
			3'd4:    op_c = tcsm_pkg::OP_SEND;
			default: op_c = tcsm_pkg::OP_NONE;
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign evt_valid   = (cnt_q != 2'd0);
	assign pop         = evt_valid && evt_ready;
	assign evt         = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= '{op: op_c, seg_seq: in_ch.seg_seq, seg_ack: in_ch.seg_ack,
				seg_flags: in_ch.seg_flags, data_len: in_ch.data_len,
				seg_src_port: in_ch.seg_src_port, initial_seq: in_ch.initial_seq};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/tcsm_back.sv -----
`default_nettype none
// Executes one event per step against the connection state and drains its results.
module tcsm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tcsm_pkg::cfg_t     cfg,
	input  tcsm_pkg::evt_t     evt,
	input  wire logic          evt_valid,
	output logic               evt_ready,
	tcsm_out_if.source         out_ch
);
	typedef enum logic [1:0] {B_IDLE = 2'b01, B_DRAIN = 2'b10} bst_t;

	bst_t           bst_q;
	tcsm_pkg::res_t res_q [tcsm_pkg::MAX_OUT];
	logic [1:0]     idx_q;
	logic [1:0]     lidx_q;

	tcsm_pkg::conn_t st_q;
	logic [31:0] sua_q, snx_q, sin_q, rnx_q;
	logic [15:0] rport_q;
	logic        hv_q;
	tcsm_pkg::seg_t hseg_q;
	logic [15:0] mem_q [tcsm_pkg::SEND_QUEUE_DEPTH];
	logic [tcsm_pkg::QPW-1:0] head_q, tail_q;
	logic [tcsm_pkg::QCW-1:0] cnt_q;

	tcsm_pkg::conn_t st;
	logic [31:0] sua, snx, sin, rnx, top, sl, c32;
	logic [15:0] rport, head_val, dlen;
	logic        hv, ok, rst, ackf, synf, finf, sd_req, sf_req, est_rx, push, pop, rewind;
	tcsm_pkg::seg_t hseg;
	tcsm_pkg::seg_t seg_v [tcsm_pkg::MAX_OUT];
	logic [1:0]  nout, lidx;
	logic [1:0]  tcmd;
	logic [6:0]  tsecs;
	logic [tcsm_pkg::QCW-1:0] cnt;
	tcsm_pkg::res_t res_v [tcsm_pkg::MAX_OUT];
	logic        take, load;

	function automatic logic [tcsm_pkg::QPW-1:0] ptr_inc(input logic [tcsm_pkg::QPW-1:0] p);
		return (p == tcsm_pkg::QPW'(tcsm_pkg::SEND_QUEUE_DEPTH - 1)) ? '0 :
			p + tcsm_pkg::QPW'(1);
	endfunction

	assign take      = (bst_q == B_DRAIN) && out_ch.ready;
	assign evt_ready = (bst_q == B_IDLE) || (take && idx_q == lidx_q);
	assign load      = evt_valid && evt_ready;

	always_comb begin
		st = st_q; sua = sua_q; snx = snx_q; sin = sin_q; rnx = rnx_q;
		rport = rport_q; hv = hv_q; hseg = hseg_q; cnt = cnt_q;
		nout = 2'd0; tcmd = tcsm_pkg::TMR_NONE; tsecs = 7'd0; dlen = 16'd0;
		for (int k = 0; k < tcsm_pkg::MAX_OUT; k++) seg_v[k] = '0;
		sd_req = 1'b0; sf_req = 1'b0; est_rx = 1'b0; push = 1'b0; pop = 1'b0;
		rewind = 1'b0; ok = 1'b0;
		rst  = (evt.seg_flags & tcsm_pkg::F_RST) != 6'd0;
		ackf = (evt.seg_flags & tcsm_pkg::F_ACK) != 6'd0;
		synf = (evt.seg_flags & tcsm_pkg::F_SYN) != 6'd0;
		finf = (evt.seg_flags & tcsm_pkg::F_FIN) != 6'd0;
		sl   = {31'd0, synf} + {16'd0, evt.data_len} + {31'd0, finf};
		top  = rnx_q + {16'd0, cfg.recv_window};
		c32  = '0;
		head_val = (cnt_q == '0) ? evt.data_len : mem_q[head_q];

		case (evt.op)
			tcsm_pkg::OP_OPEN: begin
				if (st_q == tcsm_pkg::CS_CLOSED) begin
					sua = evt.initial_seq; sin = evt.initial_seq; snx = evt.initial_seq;
					rnx = 32'd0; hv = 1'b0; cnt = '0; rewind = 1'b1;
					rport = cfg.peer_port;
					if (cfg.passive_open) begin
						st = tcsm_pkg::CS_LISTEN;
					end else begin
						hv = 1'b1;
						hseg = '{seq: evt.initial_seq, ack: 32'd0, flags: tcsm_pkg::F_SYN,
							len: 16'd0};
						snx = evt.initial_seq + 32'd1;
						seg_v[0] = hseg; nout = 2'd1;
						tcmd = tcsm_pkg::TMR_START; tsecs = tcsm_pkg::SECS_RETX;
						st = tcsm_pkg::CS_SYN_SENT;
					end
				end
			end
			tcsm_pkg::OP_SEG: begin
				case (st_q)
					tcsm_pkg::CS_LISTEN: begin
						if (!rst) begin
							if (ackf) begin
								seg_v[nout] = '{seq: evt.seg_ack, ack: 32'd0,
									flags: tcsm_pkg::F_RST, len: 16'd0};
								nout = nout + 2'd1;
							end
							if (synf) begin
								rnx = evt.seg_seq + 32'd1; rport = evt.seg_src_port;
								seg_v[nout] = '{seq: sin, ack: rnx,
									flags: tcsm_pkg::F_SYN | tcsm_pkg::F_ACK, len: 16'd0};
								nout = nout + 2'd1;
								snx = snx + 32'd1;
								st = tcsm_pkg::CS_SYN_RCVD;
							end
						end
					end
					tcsm_pkg::CS_SYN_SENT: begin
						if (ackf) begin
							if (!tcsm_pkg::in_win(sin, 1'b1, evt.seg_ack, 1'b0, snx) && !rst) begin
								seg_v[0] = '{seq: evt.seg_ack, ack: evt.seg_seq,
									flags: tcsm_pkg::F_RST, len: 16'd0};
								nout = 2'd1;
							end else if (tcsm_pkg::in_win(sua, 1'b0, evt.seg_ack, 1'b0, snx)) begin
								if (rst) begin
									st = tcsm_pkg::CS_CLOSED;
								end else if (synf) begin
									rnx = evt.seg_seq + 32'd1; sua = evt.seg_ack;
									if (sua != sin) begin
										seg_v[0] = '{seq: sua, ack: rnx, flags: tcsm_pkg::F_ACK,
											len: 16'd0};
										nout = 2'd1;
										st = tcsm_pkg::CS_ESTAB;
										if (hv) begin
											hv = 1'b0; tcmd = tcsm_pkg::TMR_STOP; tsecs = 7'd0;
										end
									end
								end
							end
						end
					end
					tcsm_pkg::CS_SYN_RCVD, tcsm_pkg::CS_ESTAB: begin
						if (cfg.recv_window == 16'd0) ok = 1'b0;
						else if (sl == 32'd0)
							ok = tcsm_pkg::in_win(rnx, 1'b0, evt.seg_seq, 1'b1, top);
						else
							ok = tcsm_pkg::in_win(rnx, 1'b0, evt.seg_seq, 1'b1, top) ||
								tcsm_pkg::in_win(rnx, 1'b0, evt.seg_seq + sl - 32'd1, 1'b1, top);
						if (!ok && !rst && !(cfg.recv_window == 16'd0 && sl == 32'd0)) begin
							seg_v[0] = '{seq: snx, ack: rnx, flags: tcsm_pkg::F_ACK, len: 16'd0};
							nout = 2'd1;
						end
						if (ok && st_q == tcsm_pkg::CS_SYN_RCVD) begin
							if (rst) begin
								st = cfg.passive_open ? tcsm_pkg::CS_LISTEN : tcsm_pkg::CS_CLOSED;
							end else if (ackf) begin
								if (tcsm_pkg::in_win(sua, 1'b0, evt.seg_ack, 1'b0, snx)) begin
									sua = evt.seg_ack; st = tcsm_pkg::CS_ESTAB;
								end else begin
									seg_v[0] = '{seq: evt.seg_ack, ack: 32'd0,
										flags: tcsm_pkg::F_RST, len: 16'd0};
									nout = 2'd1;
								end
								if (finf) st = tcsm_pkg::CS_CLOSE_WAIT;
							end
						end
						if (ok && st_q == tcsm_pkg::CS_ESTAB && !rst && ackf) begin
							est_rx = 1'b1;
							// Ack of the outstanding data segment (a held FIN is excluded).
							if (!(hv && hseg.flags[0]) && hv && evt.seg_ack == snx && sua != snx) begin
								sua = evt.seg_ack;
								hv = 1'b0; tcmd = tcsm_pkg::TMR_STOP; tsecs = 7'd0;
								sd_req = 1'b1;
							end
						end
					end
					tcsm_pkg::CS_FW1, tcsm_pkg::CS_LAST_ACK: begin
						if (ackf) begin
							if (!(hv && hseg.flags[0])) begin
								if (hv && evt.seg_ack == snx && sua != snx) begin
									sua = evt.seg_ack;
									hv = 1'b0; tcmd = tcsm_pkg::TMR_STOP; tsecs = 7'd0;
									sd_req = 1'b1;
								end
							end else if (hseg.seq + 32'd1 == evt.seg_ack) begin
								hv = 1'b0; tcmd = tcsm_pkg::TMR_STOP; tsecs = 7'd0;
								st = (st_q == tcsm_pkg::CS_FW1) ? tcsm_pkg::CS_FW2 :
									tcsm_pkg::CS_CLOSED;
							end
						end
						sf_req = (st == tcsm_pkg::CS_FW1) || (st == tcsm_pkg::CS_LAST_ACK);
					end
					tcsm_pkg::CS_FW2, tcsm_pkg::CS_TIME_WAIT, tcsm_pkg::CS_CLOSE_WAIT: begin
						if (ackf && finf) begin
							if (st_q == tcsm_pkg::CS_FW2) begin
								st = tcsm_pkg::CS_TIME_WAIT;
								tcmd = tcsm_pkg::TMR_START; tsecs = tcsm_pkg::SECS_TWAIT;
							end
							if (tcsm_pkg::in_win(sua, 1'b1, evt.seg_ack, 1'b0, snx)) begin
								sua = evt.seg_ack; rnx = evt.seg_seq + 32'd1;
								seg_v[0] = '{seq: sua, ack: rnx, flags: tcsm_pkg::F_ACK, len: 16'd0};
								nout = 2'd1;
							end
						end
					end
					default: ;
				endcase
			end
			tcsm_pkg::OP_TIMEOUT: begin
				if (st_q == tcsm_pkg::CS_SYN_SENT || st_q == tcsm_pkg::CS_FW1 ||
						st_q == tcsm_pkg::CS_LAST_ACK || st_q == tcsm_pkg::CS_ESTAB) begin
					if (hv) begin
						seg_v[0] = hseg; nout = 2'd1;
					end
					tcmd = tcsm_pkg::TMR_START; tsecs = tcsm_pkg::SECS_RETX;
				end else if (st_q == tcsm_pkg::CS_TIME_WAIT) begin
					st = tcsm_pkg::CS_CLOSED;
				end
			end
			tcsm_pkg::OP_CLOSE: begin
				if (st_q == tcsm_pkg::CS_ESTAB) begin
					sf_req = 1'b1; st = tcsm_pkg::CS_FW1;
				end else if (st_q == tcsm_pkg::CS_CLOSE_WAIT) begin
					sf_req = 1'b1; st = tcsm_pkg::CS_LAST_ACK;
				end
			end
			tcsm_pkg::OP_SEND: begin
				if (st_q == tcsm_pkg::CS_ESTAB) begin
					if (cnt_q < tcsm_pkg::QCW'(tcsm_pkg::SEND_QUEUE_DEPTH)) begin
						push = 1'b1; cnt = cnt + tcsm_pkg::QCW'(1);
					end
					sd_req = 1'b1;
				end
			end
			default: ;
		endcase

		// Start the next queued data segment.
		if (sd_req && !hv && cnt != '0) begin
			pop = 1'b1; cnt = cnt - tcsm_pkg::QCW'(1);
			hv = 1'b1;
			hseg = '{seq: sua, ack: rnx, flags: tcsm_pkg::F_ACK, len: head_val};
			seg_v[nout] = hseg; nout = nout + 2'd1;
			tcmd = tcsm_pkg::TMR_START; tsecs = tcsm_pkg::SECS_DATA;
			snx = snx + {16'd0, head_val};
		end

		// In-order receive and FIN handling in ESTABLISHED.
		if (est_rx) begin
			if (evt.seg_seq == rnx && sl != 32'd0) begin
				c32 = (sl > {16'd0, cfg.recv_window}) ? {16'd0, cfg.recv_window} : sl;
				dlen = (c32[15:0] < evt.data_len) ? c32[15:0] : evt.data_len;
				rnx = rnx + c32;
				if (hv) begin
					hseg.ack = rnx;
				end else begin
					seg_v[nout] = '{seq: sua, ack: rnx, flags: tcsm_pkg::F_ACK, len: 16'd0};
					nout = nout + 2'd1;
				end
			end
			if (finf) begin
				if (tcsm_pkg::in_win(sua, 1'b1, evt.seg_ack, 1'b0, snx)) begin
					sua = evt.seg_ack; rnx = evt.seg_seq + 32'd1;
					seg_v[nout] = '{seq: sua, ack: rnx, flags: tcsm_pkg::F_ACK, len: 16'd0};
					nout = nout + 2'd1;
				end
				st = tcsm_pkg::CS_CLOSE_WAIT;
			end
		end

		// Queue a FIN once nothing else is outstanding.
		if (sf_req && cnt == '0 && !hv) begin
			hv = 1'b1;
			hseg = '{seq: sua, ack: rnx, flags: tcsm_pkg::F_FIN | tcsm_pkg::F_ACK, len: 16'd0};
			tcmd = tcsm_pkg::TMR_START; tsecs = tcsm_pkg::SECS_FIN;
			snx = snx + 32'd1;
		end

		lidx = (nout == 2'd0) ? 2'd0 : nout - 2'd1;
		for (int k = 0; k < tcsm_pkg::MAX_OUT; k++) begin
			res_v[k] = '0;
			if (2'(k) < nout) begin
				res_v[k].emit      = 1'b1;
				res_v[k].out_seq   = seg_v[k].seq;
				res_v[k].out_ack   = seg_v[k].ack;
				res_v[k].out_flags = seg_v[k].flags;
				res_v[k].out_len   = seg_v[k].len;
				res_v[k].out_port  = rport;
			end
			res_v[k].conn_state = tcsm_pkg::conn_code(st);
			if (2'(k) == lidx) begin
				res_v[k].last        = 1'b1;
				res_v[k].timer_cmd   = tcmd;
				res_v[k].timer_secs  = tsecs;
				res_v[k].deliver_len = dlen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < tcsm_pkg::MAX_OUT; k++) res_q[k] <= res_v[k];
			sin_q  <= sin;
			hseg_q <= hseg;
			if (push) mem_q[tail_q] <= evt.data_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q   <= B_IDLE;
			idx_q   <= 2'd0;
			lidx_q  <= 2'd0;
			st_q    <= tcsm_pkg::CS_CLOSED;
			sua_q   <= '0;
			snx_q   <= '0;
			rnx_q   <= '0;
			rport_q <= '0;
			hv_q    <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (load) idx_q <= 2'd0;
			else if (take) idx_q <= idx_q + 2'd1;
			if (load) begin
				bst_q   <= B_DRAIN;
				lidx_q  <= lidx;
				st_q    <= st;
				sua_q   <= sua;
				snx_q   <= snx;
				rnx_q   <= rnx;
				rport_q <= rport;
				hv_q    <= hv;
				cnt_q   <= cnt;
				if (rewind) begin
					tail_q <= head_q;
				end else begin
					if (push) tail_q <= ptr_inc(tail_q);
					if (pop) head_q <= ptr_inc(head_q);
				end
			end else if (take && idx_q == lidx_q) begin
				bst_q <= B_IDLE;
			end
		end
	end

	assign out_ch.valid       = (bst_q == B_DRAIN);
	assign out_ch.emit        = res_q[idx_q].emit;
	assign out_ch.out_seq     = res_q[idx_q].out_seq;
	assign out_ch.out_ack     = res_q[idx_q].out_ack;
	assign out_ch.out_flags   = res_q[idx_q].out_flags;
	assign out_ch.out_len     = res_q[idx_q].out_len;
	assign out_ch.out_port    = res_q[idx_q].out_port;
	assign out_ch.conn_state  = res_q[idx_q].conn_state;
	assign out_ch.timer_cmd   = res_q[idx_q].timer_cmd;
	assign out_ch.timer_secs  = res_q[idx_q].timer_secs;
	assign out_ch.deliver_len = res_q[idx_q].deliver_len;
	assign out_ch.last        = res_q[idx_q].last;
endmodule
`default_nettype wire

// ----- rtl/tcsm_checker.sv -----
`default_nettype none
module tcsm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        o_valid,
	input wire logic        o_ready,
	input wire logic        o_emit,
	input wire logic        o_last,
	input wire logic [1:0]  o_timer_cmd,
	input wire logic [6:0]  o_timer_secs,
	input wire logic [15:0] o_deliver_len
);
	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid)
		else $error("result withdrawn while stalled");

	// Results of one event follow each other without a gap.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_ready && !o_last |=> o_valid)
		else $error("gap inside an event's results");

	// A quiet result is always the only result of its event.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_emit |-> o_last)
		else $error("quiet result not final");

	// Timer and delivery fields appear only on the final result.
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_last |-> o_timer_cmd == tcsm_pkg::TMR_NONE && o_deliver_len == 16'd0)
		else $error("tail fields on non-final result");

	a_secs: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_timer_cmd != tcsm_pkg::TMR_START |-> o_timer_secs == 7'd0)
		else $error("timer seconds without start");
endmodule

bind tcp_connection_state_machine tcsm_checker u_tcsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.o_valid       (out_ch.valid),
	.o_ready       (out_ch.ready),
	.o_emit        (out_ch.emit),
	.o_last        (out_ch.last),
	.o_timer_cmd   (out_ch.timer_cmd),
	.o_timer_secs  (out_ch.timer_secs),
	.o_deliver_len (out_ch.deliver_len)
);
`default_nettype wire
